[src/swpb_pkg.sv]
// shared types, constants and the quarter-sine gain table entry function for the width/pan block
`timescale 1ns / 1ps
package swpb_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int GAIN_DEPTH_DEF  = 1024;
    localparam int CFG_DATA_BITS   = 17;
    localparam int CFG_IDX_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_PAN_TARGET   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH_TARGET = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAN_MODE     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_STEPS   = 2'd3;

    localparam logic signed [16:0] PAN_RESET   = 17'sd0;
    localparam logic [16:0]        WIDTH_RESET = 17'd32768;
    localparam logic [15:0]        RAMP_RESET  = 16'd2400;
    localparam logic [16:0]        UNITY_GAIN  = 17'd32768;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] left_sample;
        logic signed [SAMPLE_BITS_DEF-1:0] right_sample;
        logic                              block_last;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] left_out;
        logic signed [SAMPLE_BITS_DEF-1:0] right_out;
        logic [SAMPLE_BITS_DEF-1:0]        peak_left;
        logic [SAMPLE_BITS_DEF-1:0]        peak_right;
        logic                              peak_final;
    } out_beat_t;

    // sine table entry by integer taylor series, q30 internally
    function automatic logic [16:0] sine_entry(input int k, input int depth);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      r;
        x    = (64'(k) * HALF_PI_Q30 + 64'(depth / 2)) / 64'(depth);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r < 0)
            r = 0;
        if (r > 32768)
            r = 32768;
        return 17'(r);
    endfunction

endpackage

[src/stereo_width_pan_balance.sv]
// top level: glide, mid/side width, pan or balance gains, saturation and peak metering
// one beat at a time: a new input beat is taken only in idle, once the previous beat has
// passed the state sequence around the shared 34x18 multiplier; a waiting output beat
// holds the next item before its gain multiplies
// reset: asynchronous active low; registers to their reset values, peaks cleared
`timescale 1ns / 1ps
module stereo_width_pan_balance import swpb_pkg::*; #(
    parameter int GAIN_TABLE_DEPTH = GAIN_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_beat_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_beat_t                out_data
);

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int AW = $clog2(GAIN_TABLE_DEPTH + 1);
    localparam int AB = SB + 18;  // mid/side accumulator
    localparam int PB = AB - 8 + 18;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PDIV   = 10'b0000000010,
        S_WDIV   = 10'b0000000100,
        S_STEP   = 10'b0000001000,
        S_ML     = 10'b0000010000,
        S_MR     = 10'b0000100000,
        S_ROM    = 10'b0001000000,
        S_GL     = 10'b0010000000,
        S_GR     = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [16:0] pan_target_reg;
    logic [16:0]        width_target_reg;
    logic               pan_mode_reg;
    logic [15:0]        ramp_reg;

    logic signed [34:0] cur_pan_reg, pan_inc_reg, cur_w_reg, w_inc_reg;
    logic [15:0]        pan_left_reg, w_left_reg;
    logic signed [17:0] pan_seen_reg, w_seen_reg;
    logic [SB-1:0]      pk_l_reg, pk_r_reg;

    logic signed [SB-1:0] l_reg, r_reg;
    logic                 last_reg;
    logic signed [AB-1:0] accl_reg, accr_reg;
    logic signed [17:0]   gl_reg, gr_reg;
    logic [AW-1:0]        rom_addr;
    logic [16:0]          rom_data;
    logic                 out_valid_reg;
    out_beat_t            out_reg;

    // shared multiplier, operands picked by state
    logic signed [AB-9:0] mul_a;
    logic signed [17:0]   mul_b;
    logic signed [PB-1:0] mul_p;

    logic               div_start, div_done;
    logic signed [34:0] div_dnd, div_q;
    // pan division in flight, and pan phase finished
    logic               pdiv_run_reg;
    logic               pdiv_fin;

    logic signed [17:0] pan_v, w_v;
    logic signed [SB:0] s_v, d_v;
    logic [AW+17:0]     pidx;

    logic signed [16:0] cfg_pan_cl;
    logic [16:0]        cfg_w_cl;

    swpb_gain_rom #(.GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH)) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    swpb_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dnd),
        .divisor  (ramp_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pdiv_fin  = div_done || !pdiv_run_reg;

    // clamp on write
    always_comb
    begin
        cfg_pan_cl = $signed(cfg_data);
        if ($signed(cfg_data) < -17'sd32768)
            cfg_pan_cl = -17'sd32768;
        else if ($signed(cfg_data) > 17'sd32768)
            cfg_pan_cl = 17'sd32768;
        cfg_w_cl = (cfg_data > 17'd65536) ? 17'd65536 : cfg_data;
    end

    // used values: floor of the smoothed state, clamped
    always_comb
    begin
        pan_v = cur_pan_reg[33:16];
        if (pan_v < -18'sd32768)
            pan_v = -18'sd32768;
        if (pan_v > 18'sd32768)
            pan_v = 18'sd32768;
        w_v = cur_w_reg[33:16];
        if (w_v < 18'sd0)
            w_v = 18'sd0;
        if (w_v > 18'sd65536)
            w_v = 18'sd65536;
        s_v  = SB'(0) + (SB+1)'(l_reg) + (SB+1)'(r_reg);
        d_v  = (SB+1)'(l_reg) - (SB+1)'(r_reg);
        pidx = ((AW+18)'(unsigned'(18'(pan_v + 18'sd32768))) * (AW+18)'(GAIN_TABLE_DEPTH)
               + (AW+18)'(32768)) >> 16;
        if (pidx > (AW+18)'(GAIN_TABLE_DEPTH))
            pidx = (AW+18)'(GAIN_TABLE_DEPTH);
    end

    // left gain entry is read first, right gain entry in S_ROM
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        rom_addr = AW'((AW+18)'(GAIN_TABLE_DEPTH) - pidx);
        unique case (state_reg)
            S_ML:
            begin
                mul_a = (AB-8)'(d_v);
                mul_b = w_v;
            end
            S_MR:
            begin
                mul_a = (AB-8)'(d_v);
                mul_b = w_v;
            end
            S_GL:
            begin
                mul_a = (AB-8)'(accl_reg >>> 8);
                mul_b = gl_reg;
            end
            S_GR:
            begin
                mul_a = (AB-8)'(accr_reg >>> 8);
                mul_b = gr_reg;
            end
            S_ROM:
                rom_addr = AW'(pidx);
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PB'(mul_a) * PB'(mul_b);
    end

    function automatic logic signed [SB-1:0] sat_out(input logic signed [PB-1:0] p);
        logic signed [PB-1:0] o;
        o = (p + PB'(64'sd4194304)) >>> 23;
        if (o > PB'((64'sd1 <<< (SB - 1)) - 1))
            return {1'b0, {(SB-1){1'b1}}};
        if (o < -PB'(64'sd1 <<< (SB - 1)))
            return {1'b1, {(SB-1){1'b0}}};
        return SB'(o);
    endfunction

    function automatic logic [SB-1:0] abs_v(input logic signed [SB-1:0] v);
        logic signed [SB:0] w;
        w = (SB+1)'(v);
        if (w < 0)
            w = -w;
        return SB'(w);
    endfunction

    logic signed [SB-1:0] o_tmp;
    logic [SB-1:0]        a_tmp;
    logic signed [34:0]   pan_tgt35, w_tgt35;

    assign pan_tgt35 = 35'(pan_target_reg) <<< 16;
    assign w_tgt35   = 35'($signed({1'b0, width_target_reg})) <<< 16;
    assign o_tmp     = sat_out(mul_p);
    assign a_tmp     = abs_v(o_tmp);

    always_comb
    begin
        div_start = 1'b0;
        div_dnd   = '0;
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            if (18'(pan_target_reg) != pan_seen_reg && ramp_reg != 16'd0)
            begin
                div_start = 1'b1;
                div_dnd   = pan_tgt35 - cur_pan_reg;
            end
        end
        else if (state_reg == S_PDIV && pdiv_fin)
        begin
            if ($signed({1'b0, width_target_reg}) != w_seen_reg && ramp_reg != 16'd0)
            begin
                div_start = 1'b1;
                div_dnd   = w_tgt35 - cur_w_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pan_target_reg   <= PAN_RESET;
            width_target_reg <= WIDTH_RESET;
            pan_mode_reg     <= 1'b0;
            ramp_reg         <= RAMP_RESET;
            cur_pan_reg      <= '0;
            pan_inc_reg      <= '0;
            pan_left_reg     <= '0;
            pan_seen_reg     <= '0;
            cur_w_reg        <= 35'(WIDTH_RESET) <<< 16;
            w_inc_reg        <= '0;
            w_left_reg       <= '0;
            w_seen_reg       <= 18'(WIDTH_RESET);
            pk_l_reg         <= '0;
            pk_r_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PAN_TARGET:   pan_target_reg   <= cfg_pan_cl;
                    REG_WIDTH_TARGET: width_target_reg <= cfg_w_cl;
                    REG_PAN_MODE:     pan_mode_reg     <= cfg_data[0];
                    REG_RAMP_STEPS:   ramp_reg         <= cfg_data[15:0];
                    default:          ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (18'(pan_target_reg) != pan_seen_reg)
                        begin
                            pan_seen_reg <= 18'(pan_target_reg);
                            pan_left_reg <= ramp_reg;
                            if (ramp_reg == 16'd0)
                            begin
                                cur_pan_reg <= pan_tgt35;
                                pan_inc_reg <= '0;
                            end
                        end
                    end
                end
                S_PDIV:
                begin
                    if (div_done)
                        pan_inc_reg <= div_q;
                    if ($signed({1'b0, width_target_reg}) != w_seen_reg && !div_start
                        && pdiv_fin)
                    begin
                        w_seen_reg <= $signed({1'b0, width_target_reg});
                        w_left_reg <= '0;
                        cur_w_reg  <= w_tgt35;
                        w_inc_reg  <= '0;
                    end
                    else if (div_start)
                    begin
                        w_seen_reg <= $signed({1'b0, width_target_reg});
                        w_left_reg <= ramp_reg;
                    end
                end
                S_WDIV:
                begin
                    if (div_done)
                        w_inc_reg <= div_q;
                end
                S_STEP:
                begin
                    if (pan_left_reg != 16'd0)
                    begin
                        pan_left_reg <= pan_left_reg - 16'd1;
                        cur_pan_reg  <= (pan_left_reg == 16'd1) ? (35'(pan_seen_reg) <<< 16)
                                                                : cur_pan_reg + pan_inc_reg;
                    end
                    if (w_left_reg != 16'd0)
                    begin
                        w_left_reg <= w_left_reg - 16'd1;
                        cur_w_reg  <= (w_left_reg == 16'd1) ? (35'(w_seen_reg) <<< 16)
                                                            : cur_w_reg + w_inc_reg;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (last_reg)
                    begin
                        pk_l_reg <= '0;
                        pk_r_reg <= '0;
                    end
                    else
                    begin
                        pk_l_reg <= out_reg.peak_left;
                        pk_r_reg <= out_reg.peak_right;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid && in_ready) state_next = S_PDIV;
            S_PDIV:
            begin
                // pan divide skipped when no glide started: go straight on
                if (pdiv_fin)
                    state_next = div_start ? S_WDIV : S_STEP;
            end
            S_WDIV: if (div_done) state_next = S_STEP;
            S_STEP: state_next = S_ML;
            S_ML:   state_next = S_MR;
            // hold here while the previous beat still waits at the output
            S_MR:   if (!out_valid_reg || out_ready) state_next = S_ROM;
            S_ROM:  state_next = S_GL;
            S_GL:   state_next = S_GR;
            S_GR:   state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pdiv_run_reg <= 1'b0;
        else if (state_reg == S_IDLE && div_start)
            pdiv_run_reg <= 1'b1;
        else if (div_done)
            pdiv_run_reg <= 1'b0;
    end

    // width handled directly when the pan path has no division
    // (width jump for zero ramp also taken in S_PDIV above)

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            l_reg    <= in_data.left_sample;
            r_reg    <= in_data.right_sample;
            last_reg <= in_data.block_last;
        end
        unique case (state_reg)
            S_ML: accl_reg <= (AB'(s_v) <<< 15) + AB'(mul_p);
            S_MR: accr_reg <= (AB'(s_v) <<< 15) - AB'(mul_p);
            S_ROM:
            begin
                if (pan_mode_reg)
                begin
                    gl_reg <= (pan_v < 0) ? 18'sd32768 : 18'sd32768 - pan_v;
                    gr_reg <= (pan_v < 0) ? 18'sd32768 + pan_v : 18'sd32768;
                end
            end
            S_GL:
            begin
                if (!pan_mode_reg)
                    gr_reg <= 18'(rom_data);
                out_reg.left_out   <= o_tmp;
                out_reg.peak_left  <= (a_tmp > pk_l_reg) ? a_tmp : pk_l_reg;
            end
            S_GR:
            begin
                out_reg.right_out  <= o_tmp;
                out_reg.peak_right <= (a_tmp > pk_r_reg) ? a_tmp : pk_r_reg;
                out_reg.peak_final <= last_reg;
            end
            default: ;
        endcase
        if (state_reg == S_ROM && !pan_mode_reg)
            gl_reg <= 18'(rom_data);
    end

endmodule

[src/swpb_gain_rom.sv]
// registered quarter-sine gain table, one read per cycle
`timescale 1ns / 1ps
module swpb_gain_rom import swpb_pkg::*; #(
    parameter int GAIN_TABLE_DEPTH = GAIN_DEPTH_DEF,
    localparam int AW = $clog2(GAIN_TABLE_DEPTH + 1)
) (
    input  logic          clk,
    input  logic [AW-1:0] addr,
    output logic [16:0]   data
);

    logic [16:0] rom [0:GAIN_TABLE_DEPTH];
    logic [16:0] data_reg;

    always_comb
    begin
        for (int k = 0; k <= GAIN_TABLE_DEPTH; k++)
            rom[k] = sine_entry(k, GAIN_TABLE_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

[src/swpb_divider.sv]
// restoring divider for glide increments, one quotient bit per cycle
`timescale 1ns / 1ps
module swpb_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [34:0] dividend,
    input  logic [15:0]        divisor,
    output logic               done,
    output logic signed [34:0] quotient
);

    logic [34:0] rem_reg, rem_next;
    logic [34:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [15:0] dsr_reg, dsr_next;
    logic        done_reg, done_next;
    logic [35:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[34]} - {20'd0, dsr_reg};
        if (start)
        begin
            neg_next  = dividend[34];
            quo_next  = dividend[34] ? 35'(-dividend) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd35;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[35])
            begin
                rem_next = trial[34:0];
                quo_next = {quo_reg[33:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[33:0], quo_reg[34]};
                quo_next = {quo_reg[33:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 35'(-quo_reg) : quo_reg;

endmodule

[src/swpb_checker.sv]
// port-level checker for the width/pan block, bound to the top level
`timescale 1ns / 1ps
module swpb_checker import swpb_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

    a_peak_covers_right: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.peak_right >= (out_data.right_out[23] ?
            24'(-out_data.right_out) : out_data.right_out))
        else $error("right peak below output");

    a_peak_covers_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.peak_left >= (out_data.left_out[23] ?
            24'(-out_data.left_out) : out_data.left_out))
        else $error("left peak below output");

endmodule

bind stereo_width_pan_balance swpb_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
